// ===== src/mtbs_pkg.sv =====
// Shared types, character codes and register indexes for the markup text block scanner.
// Used by the interfaces, the register file, the scan core and the top level; depends on nothing.
package mtbs_pkg;

   localparam int DEPTH_BITS    = 8;
   localparam int LENGTH_BITS   = 16;
   localparam int CHAR_BITS     = 8;
   localparam int COUNT_BITS    = 16;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [LENGTH_BITS-1:0] LENGTH_ONE = LENGTH_BITS'(1);
   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};
   localparam logic [DEPTH_BITS-1:0]  DEPTH_ONE  = DEPTH_BITS'(1);
   localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX  = {DEPTH_BITS{1'b1}};
   localparam logic [DEPTH_BITS-1:0]  DEPTH_ZERO = '0;

   localparam logic [CHAR_BITS-1:0] CH_NL     = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CHAR_BITS-1:0] CH_LBRACE = 8'h7B;
   localparam logic [CHAR_BITS-1:0] CH_RBRACE = 8'h7D;
   localparam logic [CHAR_BITS-1:0] CH_DQUOTE = 8'h22;
   localparam logic [CHAR_BITS-1:0] CH_SQUOTE = 8'h27;
   localparam logic [CHAR_BITS-1:0] CH_BSLASH = 8'h5C;

   localparam logic [CHAR_BITS-1:0] RESET_INSTANT = 8'd35;
   localparam logic [CHAR_BITS-1:0] RESET_CHAR    = 8'd64;
   localparam logic [CHAR_BITS-1:0] RESET_DEFER   = 8'd37;
   localparam logic [CHAR_BITS-1:0] RESET_SCENE   = 8'd58;
   localparam logic [CHAR_BITS-1:0] RESET_BEAT    = 8'd59;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_CHAR  = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      REG_INSTANT = 3'd0,
      REG_CHAR    = 3'd1,
      REG_DEFER   = 3'd2,
      REG_SCENE   = 3'd3,
      REG_BEAT    = 3'd4
   } reg_index_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_T_SKIP    = 4'd1,
      PH_T_RUN     = 4'd2,
      PH_T_DOUBLE  = 4'd3,
      PH_T_FORM    = 4'd4,
      PH_B_SKIP    = 4'd5,
      PH_B_BODY    = 4'd6,
      PH_B_HASH    = 4'd7,
      PH_B_STR     = 4'd8,
      PH_B_ESC     = 4'd9,
      PH_B_CMT     = 4'd10,
      PH_B_CMTHASH = 4'd11
   } phase_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] instant_code;
      logic [CHAR_BITS-1:0] char_code;
      logic [CHAR_BITS-1:0] defer_code;
      logic [CHAR_BITS-1:0] scene_code;
      logic [CHAR_BITS-1:0] beat_code;
   } cfg_type;

   typedef struct packed {
      phase_type              phase;
      logic                   mode;
      logic [DEPTH_BITS-1:0]  depth;
      logic                   any_consumed;
      logic [LENGTH_BITS-1:0] pos_count;
      logic [LENGTH_BITS-1:0] mark_pos;
      logic [LENGTH_BITS-1:0] skip_count;
      logic [CHAR_BITS-1:0]   held_sigil;
      logic                   quote_single;
      logic                   end_marked;
   } scan_state_type;

   typedef struct packed {
      logic                  done_res;
      logic                  accepted;
      logic                  token_kind;
      logic [COUNT_BITS-1:0] skipped;
      logic [COUNT_BITS-1:0] token_length;
      logic                  overflow;
   } result_type;

   function automatic scan_state_type clear_state();
      scan_state_type s;
      s.phase        = PH_IDLE;
      s.mode         = 1'b0;
      s.depth        = '0;
      s.any_consumed = 1'b0;
      s.pos_count    = '0;
      s.mark_pos     = '0;
      s.skip_count   = '0;
      s.held_sigil   = '0;
      s.quote_single = 1'b0;
      s.end_marked   = 1'b0;
      return s;
   endfunction

   function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR);
   endfunction

endpackage

// ===== src/mtbs_ifs.sv =====
// Word channel interfaces for the scanner's request and response sides.
// Widths come from mtbs_pkg.
interface mtbs_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     kind;
   logic                           mode;
   logic [mtbs_pkg::CHAR_BITS-1:0] ch;

   modport source (output valid, kind, mode, ch, input ready);
   modport sink   (input valid, kind, mode, ch, output ready);
endinterface

interface mtbs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            done_res;
   logic                            accepted;
   logic                            token_kind;
   logic [mtbs_pkg::COUNT_BITS-1:0] skipped;
   logic [mtbs_pkg::COUNT_BITS-1:0] token_length;
   logic                            overflow;

   modport source (output valid, done_res, accepted, token_kind, skipped, token_length,
                   overflow, input ready);
   modport sink   (input valid, done_res, accepted, token_kind, skipped, token_length,
                   overflow, output ready);
endinterface

// ===== src/mtbs_csr.sv =====
// APB-style register file holding the five sigil character codes.
// Depends on mtbs_pkg for the register indexes, reset codes and cfg_type.
module mtbs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mtbs_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [mtbs_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [mtbs_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready,
   output mtbs_pkg::cfg_type                   cfg
);

   mtbs_pkg::cfg_type       cfg_ff;
   mtbs_pkg::cfg_type       cfg_in;
   mtbs_pkg::reg_index_type index;
   logic                    write_en;
   logic [7:0]              read_byte;

   assign index    = mtbs_pkg::reg_index_type'(paddr[4:2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            mtbs_pkg::REG_INSTANT: cfg_in.instant_code = pwdata[7:0];
            mtbs_pkg::REG_CHAR:    cfg_in.char_code    = pwdata[7:0];
            mtbs_pkg::REG_DEFER:   cfg_in.defer_code   = pwdata[7:0];
            mtbs_pkg::REG_SCENE:   cfg_in.scene_code   = pwdata[7:0];
            mtbs_pkg::REG_BEAT:    cfg_in.beat_code    = pwdata[7:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         mtbs_pkg::REG_INSTANT: read_byte = cfg_ff.instant_code;
         mtbs_pkg::REG_CHAR:    read_byte = cfg_ff.char_code;
         mtbs_pkg::REG_DEFER:   read_byte = cfg_ff.defer_code;
         mtbs_pkg::REG_SCENE:   read_byte = cfg_ff.scene_code;
         mtbs_pkg::REG_BEAT:    read_byte = cfg_ff.beat_code;
         default:               read_byte = 8'd0;
      endcase
   end

   assign prdata = {{(mtbs_pkg::CSR_DATA_BITS-8){1'b0}}, read_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.instant_code <= mtbs_pkg::RESET_INSTANT;
         cfg_ff.char_code    <= mtbs_pkg::RESET_CHAR;
         cfg_ff.defer_code   <= mtbs_pkg::RESET_DEFER;
         cfg_ff.scene_code   <= mtbs_pkg::RESET_SCENE;
         cfg_ff.beat_code    <= mtbs_pkg::RESET_BEAT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/mtbs_core.sv =====
// Scan state register and the next-state logic that settles one word per cycle while fire is high.
// Depends on mtbs_pkg for the phase enum, state and result structs and character codes.
module mtbs_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire,
   input  mtbs_pkg::kind_type             kind,
   input  logic                           mode,
   input  logic [mtbs_pkg::CHAR_BITS-1:0] ch,
   input  mtbs_pkg::cfg_type              cfg,
   output mtbs_pkg::result_type           result
);

   mtbs_pkg::scan_state_type state_ff;
   mtbs_pkg::scan_state_type state_in;
   logic                     done_v;
   logic                     acc_v;
   logic                     ovf_v;
   logic                     go_text;
   logic                     go_body;
   logic                     go_cmt;
   logic                     form_v;
   logic [mtbs_pkg::LENGTH_BITS-1:0] len_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtbs_pkg::clear_state();
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      done_v   = 1'b0;
      acc_v    = 1'b0;
      ovf_v    = 1'b0;
      go_text  = 1'b0;
      go_body  = 1'b0;
      go_cmt   = 1'b0;
      form_v   = 1'b0;

      case (kind)
         mtbs_pkg::KIND_START: begin
            state_in       = mtbs_pkg::clear_state();
            state_in.mode  = mode;
            state_in.phase = mode ? mtbs_pkg::PH_B_SKIP : mtbs_pkg::PH_T_SKIP;
         end

         mtbs_pkg::KIND_CHAR: begin
            unique case (state_ff.phase)
               mtbs_pkg::PH_T_SKIP, mtbs_pkg::PH_B_SKIP: begin
                  if (mtbs_pkg::is_space(ch)) begin
                     if (state_ff.skip_count == mtbs_pkg::LENGTH_MAX) begin
                        state_in.phase = mtbs_pkg::PH_IDLE;
                        done_v = 1'b1;
                        ovf_v  = 1'b1;
                     end else begin
                        state_in.skip_count = state_ff.skip_count + mtbs_pkg::LENGTH_ONE;
                     end
                  end else if (state_ff.phase == mtbs_pkg::PH_T_SKIP) begin
                     state_in.phase = mtbs_pkg::PH_T_RUN;
                     go_text = 1'b1;
                  end else if (ch == mtbs_pkg::CH_RBRACE) begin
                     // An empty block body declines the scan.
                     state_in.phase = mtbs_pkg::PH_IDLE;
                     done_v = 1'b1;
                  end else begin
                     state_in.phase = mtbs_pkg::PH_B_BODY;
                     go_body = 1'b1;
                  end
               end
               mtbs_pkg::PH_T_RUN: go_text = 1'b1;
               mtbs_pkg::PH_T_DOUBLE: begin
                  if (!state_ff.any_consumed && ch == state_ff.held_sigil) begin
                     state_in.phase = mtbs_pkg::PH_IDLE;
                     done_v = 1'b1;
                  end else begin
                     state_in.mark_pos     = state_ff.pos_count;
                     state_in.end_marked   = 1'b1;
                     state_in.any_consumed = 1'b1;
                     state_in.phase        = mtbs_pkg::PH_T_RUN;
                     go_text = 1'b1;
                  end
               end
               mtbs_pkg::PH_T_FORM: begin
                  if (state_ff.held_sigil == cfg.defer_code) begin
                     form_v = (ch == mtbs_pkg::CH_LBRACE);
                  end else begin
                     form_v = (ch == mtbs_pkg::CH_LBRACE) || (ch == mtbs_pkg::CH_DQUOTE) ||
                              (ch == mtbs_pkg::CH_SQUOTE);
                  end
                  if (form_v) begin
                     state_in.phase = mtbs_pkg::PH_IDLE;
                     done_v = 1'b1;
                     acc_v  = state_ff.any_consumed;
                  end else begin
                     state_in.mark_pos     = state_ff.pos_count;
                     state_in.end_marked   = 1'b1;
                     state_in.any_consumed = 1'b1;
                     state_in.phase        = mtbs_pkg::PH_T_RUN;
                     go_text = 1'b1;
                  end
               end
               mtbs_pkg::PH_B_BODY: go_body = 1'b1;
               mtbs_pkg::PH_B_HASH: begin
                  if (ch == cfg.instant_code) begin
                     if (state_ff.pos_count == mtbs_pkg::LENGTH_MAX) begin
                        state_in.phase = mtbs_pkg::PH_IDLE;
                        done_v = 1'b1;
                        ovf_v  = 1'b1;
                     end else begin
                        state_in.pos_count = state_ff.pos_count + mtbs_pkg::LENGTH_ONE;
                        state_in.phase     = mtbs_pkg::PH_B_CMT;
                     end
                  end else begin
                     state_in.mark_pos     = state_ff.pos_count;
                     state_in.end_marked   = 1'b1;
                     state_in.any_consumed = 1'b1;
                     state_in.phase        = mtbs_pkg::PH_B_BODY;
                     go_body = 1'b1;
                  end
               end
               mtbs_pkg::PH_B_STR, mtbs_pkg::PH_B_ESC: begin
                  if (state_ff.pos_count == mtbs_pkg::LENGTH_MAX) begin
                     state_in.phase = mtbs_pkg::PH_IDLE;
                     done_v = 1'b1;
                     ovf_v  = 1'b1;
                  end else begin
                     state_in.pos_count = state_ff.pos_count + mtbs_pkg::LENGTH_ONE;
                     if (state_ff.phase == mtbs_pkg::PH_B_ESC) begin
                        state_in.phase = mtbs_pkg::PH_B_STR;
                     end else if (ch == mtbs_pkg::CH_BSLASH) begin
                        state_in.phase = mtbs_pkg::PH_B_ESC;
                     end else if (ch == (state_ff.quote_single ? mtbs_pkg::CH_SQUOTE
                                                               : mtbs_pkg::CH_DQUOTE)) begin
                        state_in.mark_pos     = state_in.pos_count;
                        state_in.end_marked   = 1'b1;
                        state_in.any_consumed = 1'b1;
                        state_in.phase        = mtbs_pkg::PH_B_BODY;
                     end
                  end
               end
               mtbs_pkg::PH_B_CMT: go_cmt = 1'b1;
               mtbs_pkg::PH_B_CMTHASH: begin
                  if (ch == cfg.instant_code) begin
                     if (state_ff.pos_count == mtbs_pkg::LENGTH_MAX) begin
                        state_in.phase = mtbs_pkg::PH_IDLE;
                        done_v = 1'b1;
                        ovf_v  = 1'b1;
                     end else begin
                        state_in.pos_count = state_ff.pos_count + mtbs_pkg::LENGTH_ONE;
                        state_in.phase     = mtbs_pkg::PH_B_BODY;
                     end
                  end else begin
                     state_in.phase = mtbs_pkg::PH_B_CMT;
                     go_cmt = 1'b1;
                  end
               end
               default: state_in = state_ff;
            endcase

            // Inside a comment: a line end hands the character back to the body.
            if (go_cmt) begin
               if (ch == mtbs_pkg::CH_NL || ch == mtbs_pkg::CH_CR) begin
                  state_in.phase = mtbs_pkg::PH_B_BODY;
                  go_body = 1'b1;
               end else if (state_in.pos_count == mtbs_pkg::LENGTH_MAX) begin
                  state_in.phase = mtbs_pkg::PH_IDLE;
                  done_v = 1'b1;
                  ovf_v  = 1'b1;
               end else begin
                  state_in.pos_count = state_in.pos_count + mtbs_pkg::LENGTH_ONE;
                  if (ch == cfg.instant_code) begin
                     state_in.phase = mtbs_pkg::PH_B_CMTHASH;
                  end
               end
            end

            if (go_text) begin
               if (ch == mtbs_pkg::CH_NL || ch == mtbs_pkg::CH_CR ||
                   ch == mtbs_pkg::CH_LBRACE) begin
                  state_in.phase = mtbs_pkg::PH_IDLE;
                  done_v = 1'b1;
                  acc_v  = state_in.any_consumed;
               end else if (state_in.pos_count == mtbs_pkg::LENGTH_MAX) begin
                  state_in.phase = mtbs_pkg::PH_IDLE;
                  done_v = 1'b1;
                  ovf_v  = 1'b1;
               end else begin
                  state_in.pos_count = state_in.pos_count + mtbs_pkg::LENGTH_ONE;
                  if (ch == cfg.scene_code || ch == cfg.beat_code ||
                      ch == mtbs_pkg::CH_SLASH) begin
                     state_in.held_sigil = ch;
                     state_in.phase      = mtbs_pkg::PH_T_DOUBLE;
                  end else if (ch == cfg.instant_code || ch == cfg.char_code ||
                               ch == cfg.defer_code) begin
                     state_in.held_sigil = ch;
                     state_in.phase      = mtbs_pkg::PH_T_FORM;
                  end else begin
                     state_in.mark_pos     = state_in.pos_count;
                     state_in.end_marked   = 1'b1;
                     state_in.any_consumed = 1'b1;
                  end
               end
            end

            if (go_body) begin
               if (ch == mtbs_pkg::CH_DQUOTE || ch == mtbs_pkg::CH_SQUOTE ||
                   ch == cfg.instant_code) begin
                  state_in.any_consumed = 1'b1;
                  if (state_in.pos_count == mtbs_pkg::LENGTH_MAX) begin
                     state_in.phase = mtbs_pkg::PH_IDLE;
                     done_v = 1'b1;
                     ovf_v  = 1'b1;
                  end else begin
                     state_in.pos_count = state_in.pos_count + mtbs_pkg::LENGTH_ONE;
                     if (ch == mtbs_pkg::CH_DQUOTE || ch == mtbs_pkg::CH_SQUOTE) begin
                        state_in.quote_single = (ch == mtbs_pkg::CH_SQUOTE);
                        state_in.phase        = mtbs_pkg::PH_B_STR;
                     end else begin
                        state_in.phase = mtbs_pkg::PH_B_HASH;
                     end
                  end
               end else if (ch == mtbs_pkg::CH_LBRACE &&
                            state_in.depth == mtbs_pkg::DEPTH_MAX) begin
                  state_in.phase = mtbs_pkg::PH_IDLE;
                  done_v = 1'b1;
                  ovf_v  = 1'b1;
               end else if (ch == mtbs_pkg::CH_RBRACE &&
                            state_in.depth == mtbs_pkg::DEPTH_ZERO) begin
                  // Closing brace of the body itself.
                  state_in.phase = mtbs_pkg::PH_IDLE;
                  done_v = 1'b1;
                  acc_v  = state_in.any_consumed;
               end else begin
                  if (ch == mtbs_pkg::CH_LBRACE) begin
                     state_in.depth = state_in.depth + mtbs_pkg::DEPTH_ONE;
                  end else if (ch == mtbs_pkg::CH_RBRACE) begin
                     state_in.depth = state_in.depth - mtbs_pkg::DEPTH_ONE;
                  end else begin
                     state_in.any_consumed = 1'b1;
                  end
                  if (state_in.pos_count == mtbs_pkg::LENGTH_MAX) begin
                     state_in.phase = mtbs_pkg::PH_IDLE;
                     done_v = 1'b1;
                     ovf_v  = 1'b1;
                  end else begin
                     state_in.pos_count = state_in.pos_count + mtbs_pkg::LENGTH_ONE;
                     if (!mtbs_pkg::is_space(ch)) begin
                        state_in.mark_pos     = state_in.pos_count;
                        state_in.end_marked   = 1'b1;
                        state_in.any_consumed = 1'b1;
                     end
                  end
               end
            end
         end

         mtbs_pkg::KIND_END: begin
            unique case (state_ff.phase)
               mtbs_pkg::PH_IDLE: state_in = state_ff;
               mtbs_pkg::PH_T_SKIP, mtbs_pkg::PH_B_SKIP: begin
                  state_in.phase = mtbs_pkg::PH_IDLE;
                  done_v = 1'b1;
               end
               mtbs_pkg::PH_T_DOUBLE, mtbs_pkg::PH_T_FORM, mtbs_pkg::PH_B_HASH,
               mtbs_pkg::PH_B_STR, mtbs_pkg::PH_B_ESC: begin
                  // A pending sigil or open string still counts as token text.
                  state_in.mark_pos     = state_ff.pos_count;
                  state_in.end_marked   = 1'b1;
                  state_in.any_consumed = 1'b1;
                  state_in.phase        = mtbs_pkg::PH_IDLE;
                  done_v = 1'b1;
                  acc_v  = 1'b1;
               end
               default: begin
                  state_in.phase = mtbs_pkg::PH_IDLE;
                  done_v = 1'b1;
                  acc_v  = state_ff.any_consumed;
               end
            endcase
         end

         default: state_in = state_ff;
      endcase
   end

   assign len_v = state_in.end_marked ? state_in.mark_pos : state_in.pos_count;

   assign result.done_res     = done_v;
   assign result.accepted     = acc_v;
   assign result.token_kind   = done_v & state_in.mode;
   assign result.skipped      = acc_v ? mtbs_pkg::COUNT_BITS'(state_in.skip_count)
                                      : '0;
   assign result.token_length = acc_v ? mtbs_pkg::COUNT_BITS'(len_v) : '0;
   assign result.overflow     = ovf_v;

   a_accept_settles : assert property (@(posedge clock) disable iff (reset)
      (fire && (acc_v || ovf_v)) |=> (state_ff.phase == mtbs_pkg::PH_IDLE))
      else $error("settled scan did not return to idle");

   a_ovf_declines : assert property (@(posedge clock) disable iff (reset)
      (fire && ovf_v) |-> (done_v && !acc_v))
      else $error("overflow reported on an accepted or unsettled scan");

   a_start_opens : assert property (@(posedge clock) disable iff (reset)
      (fire && kind == mtbs_pkg::KIND_START) |=>
         (state_ff.pos_count == '0 && state_ff.phase != mtbs_pkg::PH_IDLE))
      else $error("start word did not open a fresh scan");

endmodule

// ===== src/markup_text_block_scanner.sv =====
// Top level of the markup text block scanner: word channels, pipeline registers and wiring.
// Depends on mtbs_pkg, mtbs_ifs (mtbs_req_if, mtbs_rsp_if), mtbs_csr and mtbs_core.
//
// The scanner takes one word per clock while results are taken, and answers every word
// with exactly one result word: the word is captured in an input register, the scan core
// settles it against the running scan state once the result register is empty or being
// drained, and the answer lands in the result register. A new word may follow every
// cycle unless the result side holds off; there is a single scan-state
// register that each word updates in turn. A start word opens a text or block scan,
// character words feed it, and an end word closes it; the result carries done_res
// high on the word that settles the scan. When the result register is full and not
// being taken, one further word is still accepted and waits in the input register.
// The sigil codes live in five byte-wide registers at byte addresses 0, 4, 8, 12 and
// 16 of the APB-style port; they should only be rewritten while the scanner is idle.
module markup_text_block_scanner (
   input  logic                               clock,
   input  logic                               reset,
   mtbs_req_if.sink                           req_bus,
   mtbs_rsp_if.source                         rsp_bus,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mtbs_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [mtbs_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [mtbs_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);

   // Input register stage.
   logic                           in_valid_ff;
   logic                           in_valid_in;
   mtbs_pkg::kind_type             in_kind_ff;
   logic                           in_mode_ff;
   logic [mtbs_pkg::CHAR_BITS-1:0] in_ch_ff;

   // Result register stage.
   logic                           out_valid_ff;
   logic                           out_valid_in;
   mtbs_pkg::result_type           out_res_ff;

   mtbs_pkg::cfg_type              cfg;
   mtbs_pkg::result_type           core_res;
   logic                           advance;
   logic                           accept;

   // The held word moves on whenever the result register is empty or being drained.
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign accept        = req_bus.valid && req_bus.ready;

   assign in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset; their valid bits guard them.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_kind_ff <= mtbs_pkg::kind_type'(req_bus.kind);
         in_mode_ff <= req_bus.mode;
         in_ch_ff   <= req_bus.ch;
      end
      if (advance) begin
         out_res_ff <= core_res;
      end
   end

   mtbs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mtbs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .kind   (in_kind_ff),
      .mode   (in_mode_ff),
      .ch     (in_ch_ff),
      .cfg    (cfg),
      .result (core_res)
   );

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.done_res     = out_res_ff.done_res;
   assign rsp_bus.accepted     = out_res_ff.accepted;
   assign rsp_bus.token_kind   = out_res_ff.token_kind;
   assign rsp_bus.skipped      = out_res_ff.skipped;
   assign rsp_bus.token_length = out_res_ff.token_length;
   assign rsp_bus.overflow     = out_res_ff.overflow;

   // A word may only enter a full input register if the held word leaves at once.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (accept && in_valid_ff) |-> advance)
      else $error("input register overwritten before its word moved on");

   // Every word that moves on shows up as a result in the next cycle.
   a_advance_loads : assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced word did not reach the result register");

   // An accepted token is always a settling result.
   a_accept_done : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_res_ff.accepted) |-> out_res_ff.done_res)
      else $error("token accepted without settling the scan");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for markup_text_block_scanner: a queue-fed word driver, a result
// monitor with an in-line scan predictor, and sigil register writes over the APB-style port.
// Depends on mtbs_pkg, the mtbs_req_if and mtbs_rsp_if interfaces and the scanner itself.
module testbench;
   import mtbs_pkg::*;

   // Kind 3 is not defined by the package; the scanner must ignore it.
   localparam logic [1:0]           KIND_SPARE       = 2'd3;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_A       = "a";
   localparam int                   LONG_HOLD_CYCLES = 120;
   localparam int                   MAX_REPORTS      = 40;
   localparam int                   SETTINGS_COUNT   = 8;
   localparam int                   WORDS_PER_PHASE  = 195;
   // One more step than a length counter can take.
   localparam int                   LONG_RUN         = 1 << LENGTH_BITS;

   typedef struct packed {
      logic [1:0]           kind;
      logic                 mode;
      logic [CHAR_BITS-1:0] ch;
   } word_type;

   logic clock;
   logic reset = 1'b1;

   // Request side, driven at the falling edge.
   logic                 req_valid = 1'b0;
   logic [1:0]           req_kind  = KIND_START;
   logic                 req_mode  = 1'b0;
   logic [CHAR_BITS-1:0] req_ch    = '0;
   logic                 rsp_ready = 1'b0;

   // Register port.
   logic                     psel    = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr   = '0;
   logic [CSR_DATA_BITS-1:0] pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   mtbs_req_if req_if ();
   mtbs_rsp_if rsp_if ();

   assign req_if.valid = req_valid;
   assign req_if.kind  = req_kind;
   assign req_if.mode  = req_mode;
   assign req_if.ch    = req_ch;
   assign rsp_if.ready = rsp_ready;

   markup_text_block_scanner u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Words waiting to be offered, and the results that accepted words must produce.
   word_type   pending_words[$];
   result_type expected_results[$];

   // Handshakes seen at the last rising edge, for the processes that run at the falling edge.
   logic req_fired = 1'b0;
   logic rsp_fired = 1'b0;

   // When set, neither side idles; used for bursts and for the very long scans.
   bit steady = 1'b0;

   int words_queued   = 0;
   int words_accepted = 0;
   int errors         = 0;
   int scans_settled  = 0;
   int scans_taken    = 0;
   int scans_limited  = 0;
   int settings_used  = 1;

   // The receiver counts its own long hold-offs against the requests made by the stimulus.
   int long_holds_requested = 0;
   int long_holds_started   = 0;
   int hold_left            = 0;
   int stall_left           = 0;
   int gap_left             = 0;

   // ---------------------------------------------------------------------------------------
   // Scan predictor. It mirrors the sigil registers and the running scan state, and works
   // out the result of every accepted word in acceptance order.
   // ---------------------------------------------------------------------------------------
   cfg_type                sigils;
   phase_type              ph;
   logic                   sc_mode;
   logic [DEPTH_BITS-1:0]  nest;
   logic                   consumed;
   logic [LENGTH_BITS-1:0] pos;
   logic [LENGTH_BITS-1:0] mark_at;
   logic [LENGTH_BITS-1:0] skips;
   logic [CHAR_BITS-1:0]   held;
   logic                   single_quote;
   logic                   marked;
   logic                   r_done;
   logic                   r_acc;
   logic                   r_ovf;

   function automatic logic is_blank(input logic [CHAR_BITS-1:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR;
   endfunction

   // Drops whatever scan is open; the mode is set by the caller.
   function automatic void open_scan(input logic mode);
      sc_mode      = mode;
      ph           = mode ? PH_B_SKIP : PH_T_SKIP;
      nest         = '0;
      consumed     = 1'b0;
      pos          = '0;
      mark_at      = '0;
      skips        = '0;
      held         = '0;
      single_quote = 1'b0;
      marked       = 1'b0;
   endfunction

   function automatic void settle_scan(input logic acc, input logic ovf);
      r_done = 1'b1;
      r_acc  = acc;
      r_ovf  = ovf;
      ph     = PH_IDLE;
   endfunction

   // Advances the position; at the top of the counter the scan is declined instead.
   function automatic logic step_position();
      if (pos == LENGTH_MAX) begin
         settle_scan(1'b0, 1'b1);
         return 1'b0;
      end
      pos++;
      return 1'b1;
   endfunction

   function automatic void mark_token_end();
      mark_at  = pos;
      marked   = 1'b1;
      consumed = 1'b1;
   endfunction

   function automatic void count_skip();
      if (skips == LENGTH_MAX) settle_scan(1'b0, 1'b1);
      else skips++;
   endfunction

   function automatic void text_step(input logic [CHAR_BITS-1:0] c);
      if (c == CH_NL || c == CH_CR || c == CH_LBRACE) begin
         settle_scan(consumed, 1'b0);
      end else if (c == sigils.scene_code || c == sigils.beat_code || c == CH_SLASH) begin
         if (step_position()) begin
            held = c;
            ph   = PH_T_DOUBLE;
         end
      end else if (c == sigils.instant_code || c == sigils.char_code
                   || c == sigils.defer_code) begin
         if (step_position()) begin
            held = c;
            ph   = PH_T_FORM;
         end
      end else if (step_position()) begin
         mark_token_end();
      end
   endfunction

   function automatic void body_step(input logic [CHAR_BITS-1:0] c);
      if (c == CH_DQUOTE || c == CH_SQUOTE) begin
         consumed = 1'b1;
         if (step_position()) begin
            single_quote = (c == CH_SQUOTE);
            ph           = PH_B_STR;
         end
      end else if (c == sigils.instant_code) begin
         consumed = 1'b1;
         if (step_position()) ph = PH_B_HASH;
      end else if (c == CH_LBRACE) begin
         if (nest == DEPTH_MAX) begin
            settle_scan(1'b0, 1'b1);
         end else begin
            nest++;
            if (step_position()) mark_token_end();
         end
      end else if (c == CH_RBRACE) begin
         if (nest == DEPTH_ZERO) begin
            settle_scan(consumed, 1'b0);
         end else begin
            nest--;
            if (step_position()) mark_token_end();
         end
      end else begin
         consumed = 1'b1;
         if (step_position() && !is_blank(c)) mark_token_end();
      end
   endfunction

   function automatic void comment_step(input logic [CHAR_BITS-1:0] c);
      if (c == CH_NL || c == CH_CR) begin
         ph = PH_B_BODY;
         body_step(c);
      end else if (c == sigils.instant_code) begin
         if (step_position()) ph = PH_B_CMTHASH;
      end else begin
         void'(step_position());
      end
   endfunction

   function automatic void feed_char(input logic [CHAR_BITS-1:0] c);
      logic form;
      case (ph)
         PH_T_SKIP: begin
            if (is_blank(c)) begin
               count_skip();
            end else begin
               ph = PH_T_RUN;
               text_step(c);
            end
         end
         PH_T_RUN: text_step(c);
         PH_T_DOUBLE: begin
            if (!consumed && c == held) begin
               settle_scan(1'b0, 1'b0);
            end else begin
               mark_token_end();
               ph = PH_T_RUN;
               text_step(c);
            end
         end
         PH_T_FORM: begin
            if (held == sigils.defer_code) form = (c == CH_LBRACE);
            else form = (c == CH_LBRACE || c == CH_DQUOTE || c == CH_SQUOTE);
            if (form) begin
               settle_scan(consumed, 1'b0);
            end else begin
               mark_token_end();
               ph = PH_T_RUN;
               text_step(c);
            end
         end
         PH_B_SKIP: begin
            if (is_blank(c)) begin
               count_skip();
            end else if (c == CH_RBRACE) begin
               settle_scan(1'b0, 1'b0);
            end else begin
               ph = PH_B_BODY;
               body_step(c);
            end
         end
         PH_B_BODY: body_step(c);
         PH_B_HASH: begin
            if (c == sigils.instant_code) begin
               if (step_position()) ph = PH_B_CMT;
            end else begin
               mark_token_end();
               ph = PH_B_BODY;
               body_step(c);
            end
         end
         PH_B_STR: begin
            if (c == CH_BSLASH) begin
               if (step_position()) ph = PH_B_ESC;
            end else if (c == (single_quote ? CH_SQUOTE : CH_DQUOTE)) begin
               if (step_position()) begin
                  mark_token_end();
                  ph = PH_B_BODY;
               end
            end else begin
               void'(step_position());
            end
         end
         PH_B_ESC: begin
            if (step_position()) ph = PH_B_STR;
         end
         PH_B_CMT: comment_step(c);
         PH_B_CMTHASH: begin
            if (c == sigils.instant_code) begin
               if (step_position()) ph = PH_B_BODY;
            end else begin
               ph = PH_B_CMT;
               comment_step(c);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void end_of_input();
      case (ph)
         PH_IDLE: ;
         PH_T_SKIP, PH_B_SKIP: settle_scan(1'b0, 1'b0);
         PH_T_DOUBLE, PH_T_FORM, PH_B_HASH, PH_B_STR, PH_B_ESC: begin
            mark_token_end();
            settle_scan(1'b1, 1'b0);
         end
         default: settle_scan(consumed, 1'b0);
      endcase
   endfunction

   // The result word that the scanner must give for one accepted request word.
   function automatic result_type scan_word(input word_type w);
      result_type             res;
      logic [LENGTH_BITS-1:0] len;
      r_done = 1'b0;
      r_acc  = 1'b0;
      r_ovf  = 1'b0;
      case (w.kind)
         KIND_START: open_scan(w.mode);
         KIND_CHAR:  feed_char(w.ch);
         KIND_END:   end_of_input();
         default:    ;
      endcase
      len              = marked ? mark_at : pos;
      res.done_res     = r_done;
      res.accepted     = r_acc;
      res.token_kind   = r_done ? sc_mode : 1'b0;
      res.skipped      = r_acc ? COUNT_BITS'(skips) : '0;
      res.token_length = r_acc ? COUNT_BITS'(len) : '0;
      res.overflow     = r_ovf;
      return res;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Clock, driver, receiver and monitor.
   // ---------------------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The driver offers one word at a time, holds it until it is taken and then waits a
   // drawn number of cycles before the next one.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || req_fired) begin
         if (req_valid) gap_left = steady ? 0 : $urandom_range(0, 15);
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            req_valid <= 1'b1;
            req_kind  <= pending_words[0].kind;
            req_mode  <= pending_words[0].mode;
            req_ch    <= pending_words[0].ch;
            void'(pending_words.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The receiver stalls for a drawn number of cycles after each word it takes, and now
   // and then holds off for a long stretch so that the scanner backs up into its input.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (long_holds_started != long_holds_requested) begin
            long_holds_started++;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (rsp_ready && rsp_fired) stall_left = steady ? 0 : $urandom_range(0, 15);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic [COUNT_BITS-1:0] want,
                              input logic [COUNT_BITS-1:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   task automatic check_result();
      result_type got;
      result_type want;
      got.done_res     = rsp_if.done_res;
      got.accepted     = rsp_if.accepted;
      got.token_kind   = rsp_if.token_kind;
      got.skipped      = rsp_if.skipped;
      got.token_length = rsp_if.token_length;
      got.overflow     = rsp_if.overflow;
      if (expected_results.size() == 0) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: result word with none expected, expected nothing, got %h",
                     $time, got);
      end else begin
         want = expected_results.pop_front();
         check_field("done_res", want.done_res, got.done_res);
         check_field("accepted", want.accepted, got.accepted);
         check_field("token_kind", want.token_kind, got.token_kind);
         check_field("skipped", want.skipped, got.skipped);
         check_field("token_length", want.token_length, got.token_length);
         check_field("overflow", want.overflow, got.overflow);
         if (want.done_res) begin
            scans_settled++;
            if (want.accepted) scans_taken++;
            if (want.overflow) scans_limited++;
         end
      end
   endtask

   // Both handshakes are sampled at the rising edge. Results are checked before the word
   // accepted at the same edge is predicted; it cannot be answered yet.
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
         rsp_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && req_if.ready;
         rsp_fired <= rsp_if.valid && rsp_ready;
         if (rsp_if.valid && rsp_ready) check_result();
         if (req_valid && req_if.ready) begin
            expected_results.push_back(scan_word('{req_kind, req_mode, req_ch}));
            words_accepted++;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------------------
   task automatic push_word(input logic [1:0] kind, input logic mode,
                            input logic [CHAR_BITS-1:0] c);
      pending_words.push_back('{kind, mode, c});
      words_queued++;
   endtask

   // The fields that a kind does not use are random, so that every bit toggles.
   task automatic send_start(input logic mode);
      push_word(KIND_START, mode, CHAR_BITS'($urandom_range(0, 255)));
   endtask

   task automatic send_char(input logic [CHAR_BITS-1:0] c);
      push_word(KIND_CHAR, 1'($urandom_range(0, 1)), c);
   endtask

   task automatic send_end();
      push_word(KIND_END, 1'($urandom_range(0, 1)), CHAR_BITS'($urandom_range(0, 255)));
   endtask

   function automatic logic [CHAR_BITS-1:0] letter();
      return CH_LOWER_A + CHAR_BITS'($urandom_range(0, 25));
   endfunction

   function automatic logic [CHAR_BITS-1:0] blank_char();
      case ($urandom_range(0, 3))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_NL;
         default: return CH_CR;
      endcase
   endfunction

   // Any character, weighted towards the ones that steer the scan under the current sigils.
   function automatic logic [CHAR_BITS-1:0] any_char();
      case ($urandom_range(0, 15))
         0, 1, 2, 3: return letter();
         4, 5:       return blank_char();
         6:          return sigils.instant_code;
         7:          return sigils.char_code;
         8:          return sigils.defer_code;
         9:          return $urandom_range(0, 1) ? sigils.scene_code : sigils.beat_code;
         10:         return CH_SLASH;
         11:         return $urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE;
         12:         return $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
         13:         return CH_BSLASH;
         default:    return CHAR_BITS'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [CHAR_BITS-1:0] plain_char();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return letter();
         6:                return CH_SPACE;
         default:          return any_char();
      endcase
   endfunction

   function automatic logic [CHAR_BITS-1:0] sigil_value();
      return $urandom_range(0, 2) == 0 ? any_char() : CHAR_BITS'($urandom_range(0, 255));
   endfunction

   // A text run: optional leading blanks, maybe an often doubled mark, text, usually an ending.
   task automatic text_scan();
      logic [CHAR_BITS-1:0] c;
      send_start(1'b0);
      repeat ($urandom_range(0, 3)) send_char(blank_char());
      if ($urandom_range(0, 5) == 0) begin
         case ($urandom_range(0, 2))
            0:       c = sigils.scene_code;
            1:       c = sigils.beat_code;
            default: c = CH_SLASH;
         endcase
         send_char(c);
         if ($urandom_range(0, 2) != 0) send_char(c);
      end
      repeat ($urandom_range(0, 10)) send_char(plain_char());
      case ($urandom_range(0, 9))
         0, 1, 2, 3: send_char($urandom_range(0, 1) ? CH_NL : CH_CR);
         4:          send_char(CH_LBRACE);
         5: begin
            case ($urandom_range(0, 2))
               0:       send_char(sigils.instant_code);
               1:       send_char(sigils.char_code);
               default: send_char(sigils.defer_code);
            endcase
            case ($urandom_range(0, 2))
               0:       send_char(CH_LBRACE);
               1:       send_char(CH_DQUOTE);
               default: send_char(CH_SQUOTE);
            endcase
         end
         6, 7:    send_end();
         default: ;
      endcase
   endtask

   // A block body built from words, nested braces, quoted strings and comments, mostly
   // well formed, usually closed by the brace at depth zero.
   task automatic block_scan();
      int                   depth;
      logic [CHAR_BITS-1:0] quote;
      depth = 0;
      send_start(1'b1);
      repeat ($urandom_range(0, 2)) send_char(blank_char());
      repeat ($urandom_range(0, 8)) begin
         case ($urandom_range(0, 9))
            0, 1: repeat ($urandom_range(1, 4)) send_char(letter());
            2:    send_char(blank_char());
            3: begin
               send_char(CH_LBRACE);
               depth++;
            end
            4: begin
               if (depth > 0) begin
                  send_char(CH_RBRACE);
                  depth--;
               end
            end
            5: begin
               quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
               send_char(quote);
               repeat ($urandom_range(0, 4)) begin
                  if ($urandom_range(0, 3) == 0) send_char(CH_BSLASH);
                  send_char(any_char());
               end
               if ($urandom_range(0, 5) != 0) send_char(quote);
            end
            6: begin
               send_char(sigils.instant_code);
               send_char(sigils.instant_code);
               repeat ($urandom_range(0, 4)) send_char(plain_char());
               if ($urandom_range(0, 1)) begin
                  send_char(sigils.instant_code);
                  if ($urandom_range(0, 4) != 0) send_char(sigils.instant_code);
               end else begin
                  send_char(CH_NL);
               end
            end
            7: begin
               send_char(sigils.instant_code);
               send_char(plain_char());
            end
            default: send_char(any_char());
         endcase
      end
      repeat (depth) send_char(CH_RBRACE);
      repeat ($urandom_range(0, 2)) send_char(blank_char());
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5, 6: send_char(CH_RBRACE);
         7, 8:                send_end();
         default:             ;
      endcase
   endtask

   // Words with every field random, spare kinds and strays outside a scan among them.
   task automatic noise_words();
      repeat ($urandom_range(1, 3))
         push_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   CHAR_BITS'($urandom_range(0, 255)));
   endtask

   // Adds random scans until the given number of words has been queued. The queue is kept
   // short so that changes of pace take effect while the words are being sent.
   task automatic random_scans(input int count);
      int stop_at;
      stop_at = words_queued + count;
      while (words_queued < stop_at) begin
         while (pending_words.size() > 8) @(posedge clock);
         steady = ($urandom_range(0, 5) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3:       text_scan();
            4, 5, 6, 7, 8:    block_scan();
            default:          noise_words();
         endcase
      end
   endtask

   // Waits until every queued word has been taken and answered.
   task automatic drain();
      do @(negedge clock);
      while (words_accepted != words_queued || expected_results.size() != 0);
   endtask

   task automatic write_register(input reg_index_type index,
                                 input logic [CHAR_BITS-1:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CSR_ADDR_BITS'(4 * index);
      pwdata  = CSR_DATA_BITS'(value);
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      case (index)
         REG_INSTANT: sigils.instant_code = value;
         REG_CHAR:    sigils.char_code    = value;
         REG_DEFER:   sigils.defer_code   = value;
         REG_SCENE:   sigils.scene_code   = value;
         REG_BEAT:    sigils.beat_code    = value;
         default:     ;
      endcase
   endtask

   // The sigils are only rewritten once the scanner has answered everything, plus a few
   // cycles for its two-stage pipeline to settle.
   task automatic apply_sigils(input cfg_type s);
      drain();
      repeat (4) @(negedge clock);
      write_register(REG_INSTANT, s.instant_code);
      write_register(REG_CHAR, s.char_code);
      write_register(REG_DEFER, s.defer_code);
      write_register(REG_SCENE, s.scene_code);
      write_register(REG_BEAT, s.beat_code);
      settings_used++;
   endtask

   // Short directed opening under the reset sigils.
   task automatic directed_words();
      push_word(KIND_CHAR, 1'b1, 8'hFF);    // character with no scan open
      push_word(KIND_END, 1'b0, 8'h00);     // end of input with no scan open
      push_word(KIND_SPARE, 1'b1, 8'hFF);   // spare kind
      // A doubled scene mark after a leading blank declines the text scan.
      push_word(KIND_START, 1'b0, 8'h00);
      send_char(CH_SPACE);
      send_char(RESET_SCENE);
      send_char(RESET_SCENE);
      // A block scan dropped by a new start; then a run cut short by a character form.
      push_word(KIND_START, 1'b1, 8'hFF);
      push_word(KIND_START, 1'b0, 8'h00);
      send_char("a");
      send_char(RESET_CHAR);
      send_char(CH_LBRACE);
      // A body that holds nothing but a comment and a line break is never marked, so its
      // length runs to the closing brace.
      push_word(KIND_START, 1'b1, 8'h00);
      send_char(CH_TAB);
      send_char(RESET_INSTANT);
      send_char(RESET_INSTANT);
      send_char("z");
      send_char(CH_NL);
      send_char(CH_RBRACE);
      // End of input inside an escape within a string still gives a token.
      push_word(KIND_START, 1'b1, 8'hFF);
      send_char(CH_DQUOTE);
      send_char(CH_BSLASH);
      push_word(KIND_END, 1'b1, 8'h00);
   endtask

   // Scans that run into the depth and length limits, sent back to back.
   task automatic limit_scans();
      steady = 1'b1;
      send_start(1'b1);
      repeat (1 << DEPTH_BITS) send_char(CH_LBRACE);
      send_start(1'b0);
      repeat (LONG_RUN) send_char(letter());
      send_start(1'b1);
      repeat (LONG_RUN) send_char(blank_char());
      send_start(1'b1);
      send_char(CH_DQUOTE);
      repeat (LONG_RUN) send_char(letter());
      drain();
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------------------------
   initial begin
      cfg_type s;
      sigils = '{RESET_INSTANT, RESET_CHAR, RESET_DEFER, RESET_SCENE, RESET_BEAT};
      open_scan(1'b0);
      ph = PH_IDLE;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed_words();
      random_scans(WORDS_PER_PHASE);
      limit_scans();

      for (int p = 1; p < SETTINGS_COUNT; p++) begin
         case (p)
            1: s = '0;
            2: s = '1;
            // Sigils that collide with newline, the opening brace, the double quote and the slash.
            3: s = '{CH_NL, CH_LBRACE, CH_DQUOTE, CH_SLASH, CH_SLASH};
            // All form sigils the same, scene and beat the same.
            4: s = '{RESET_INSTANT, RESET_INSTANT, RESET_INSTANT, RESET_SCENE, RESET_SCENE};
            SETTINGS_COUNT - 1:
               s = '{RESET_INSTANT, RESET_CHAR, RESET_DEFER, RESET_SCENE, RESET_BEAT};
            default: s = '{sigil_value(), sigil_value(), sigil_value(), sigil_value(),
                           sigil_value()};
         endcase
         apply_sigils(s);
         random_scans(WORDS_PER_PHASE / 2);
         if (p == 5) begin
            // Long receiver hold-off while the sender keeps offering words.
            long_holds_requested++;
         end else if (p == 6) begin
            // The sender stops until everything sent so far has been answered.
            drain();
         end
         random_scans(WORDS_PER_PHASE / 2);
      end

      drain();
      repeat (10) @(negedge clock);
      $display("Sent %0d words; %0d scans settled, %0d gave a token, %0d hit a limit.",
               words_accepted, scans_settled, scans_taken, scans_limited);
      $display("Sigil settings used: %0d, with all-zero, all-ones and colliding codes.",
               settings_used);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches found", errors);
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Guard against a hang; the slowest correct run is a small fraction of this.
   initial begin
      #15_000_000;
      $display("Timed out at %0t with %0d results outstanding", $time,
               expected_results.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
src/mtbs_pkg.sv
src/mtbs_ifs.sv
src/mtbs_csr.sv
src/mtbs_core.sv
src/markup_text_block_scanner.sv
test/testbench.sv
